@@ rtl/mrpi_pkg.sv @@
// mrpi_pkg: shared types and constants for the mobile robot pose integrator
// used by mrpi_serial_alu and mobile_robot_pose_integrator_core
`timescale 1ns / 1ps
`default_nettype none
package mrpi_pkg;
   localparam int unsigned CORDIC_GAIN_Q30 = 32'd652032874;
   localparam int unsigned INV_PI_Q32 = 32'd1367130551;

   typedef enum logic [1:0] {
      MODE_DIFF  = 2'd0,
      MODE_OMNI  = 2'd1,
      MODE_OMNIW = 2'd2,
      MODE_ACKER = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_MODE = 2'd0,
      REG_STEP = 2'd1,
      REG_AXLE = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1
   } alu_op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECIDE,
      ST_TRIG0, ST_TRIG_RUN, ST_TRIG_DONE,
      ST_OMEGA_DT, ST_OMEGA_BAM1, ST_OMEGA_BAM2, ST_OMEGA_BAM3,
      ST_TURN_ADD,
      ST_MV1, ST_MV2, ST_MV3, ST_MV4, ST_MV5, ST_MV6, ST_MV7, ST_MV8,
      ST_ARC1, ST_ARC2, ST_ARC3, ST_ARC4,
      ST_TAN, ST_ACK1, ST_ACK2,
      ST_DONE
   } state_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
         5'd6: r = 32'd10680862;   5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
         5'd20: r = 32'd652;       5'd21: r = 32'd326;
         5'd22: r = 32'd163;       5'd23: r = 32'd81;
         5'd24: r = 32'd41;        5'd25: r = 32'd20;
         5'd26: r = 32'd10;        5'd27: r = 32'd5;
         5'd28: r = 32'd3;         5'd29: r = 32'd1;
         5'd30: r = 32'd1;         default: r = 32'd0;
      endcase
      return r;
   endfunction
endpackage
`default_nettype wire

@@ rtl/mrpi_serial_alu.sv @@
// mrpi_serial_alu: signed bit-serial multiplier (shift-add) and divider
// (restoring, truncates toward zero); depends on mrpi_pkg
`timescale 1ns / 1ps
`default_nettype none
module mrpi_serial_alu (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire mrpi_pkg::alu_op_type op,
   input  wire logic signed [95:0]  opa,
   input  wire logic signed [63:0]  opb,
   output logic                     busy,
   output logic signed [95:0]       result
);
   import mrpi_pkg::*;

   logic [95:0] acc_ff, acc_in;
   logic [95:0] sh_ff, sh_in;
   logic [63:0] mb_ff, mb_in;
   logic [95:0] rem_ff, rem_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic        div_ff, div_in;
   logic        busy_ff, busy_in;
   logic [95:0] ma, rtry;
   logic [63:0] mbv;
   logic [96:0] diff;

   always_comb begin
      ma = opa[95] ? 96'(-opa) : 96'(opa);
      mbv = opb[63] ? 64'(-opb) : 64'(opb);
      acc_in = acc_ff; sh_in = sh_ff; mb_in = mb_ff; rem_in = rem_ff;
      cnt_in = cnt_ff; neg_in = neg_ff; div_in = div_ff; busy_in = busy_ff;
      rtry = {rem_ff[94:0], sh_ff[95]};
      diff = {1'b0, rtry} - {33'd0, mb_ff};
      if (start) begin
         busy_in = 1'b1;
         div_in = (op == OP_DIV);
         neg_in = opa[95] ^ opb[63];
         acc_in = '0; rem_in = '0;
         sh_in = ma; mb_in = mbv; cnt_in = '0;
      end else if (busy_ff) begin
         if (div_ff) begin
            sh_in = {sh_ff[94:0], ~diff[96]};
            rem_in = diff[96] ? rtry : diff[95:0];
            if (cnt_ff == 7'd95) busy_in = 1'b0;
         end else begin
            if (mb_ff[0]) acc_in = acc_ff + sh_ff;
            sh_in = {sh_ff[94:0], 1'b0};
            mb_in = {1'b0, mb_ff[63:1]};
            if (cnt_ff == 7'd63) busy_in = 1'b0;
         end
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; sh_ff <= sh_in; mb_ff <= mb_in; rem_ff <= rem_in;
      neg_ff <= neg_in; div_ff <= div_in;
   end

   always_comb begin
      if (div_ff) result = neg_ff ? 96'(-sh_ff) : 96'(sh_ff);
      else        result = neg_ff ? 96'(-acc_ff) : 96'(acc_ff);
   end
   assign busy = busy_ff;
endmodule
`default_nettype wire

@@ rtl/mobile_robot_pose_integrator_core.sv @@
// mobile_robot_pose_integrator_core: dead-reckoning pose integrator top level
// depends on mrpi_pkg and mrpi_serial_alu
//
//  channel  ports       direction  width
//  req      opcode,a-c  in         1+3x32
//  rsp      pose,steer  out        4x32
//  csr      apb         in/out     32
//
// one item at a time; a step uses the serial multiply/divide unit and
// one cordic iteration per cycle. synchronous reset clears the pose and
// sets the registers to their defaults. req_stall is high while an item is
// at work or its result waits.
`timescale 1ns / 1ps
`default_nettype none
module mobile_robot_pose_integrator_core #(
   parameter int FRAC_BITS  = 16,
   parameter int TRIG_STEPS = 24
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_action_a,
   input  wire logic signed [31:0] req_action_b,
   input  wire logic signed [31:0] req_action_c,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_pos_x,
   output logic signed [31:0]      rsp_pos_y,
   output logic signed [31:0]      rsp_heading_out,
   output logic signed [31:0]      rsp_steer_out,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [3:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);
   import mrpi_pkg::*;

   localparam int ARC_SH = 30 - FRAC_BITS;

   state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [15:0] dt_ff;
   logic [23:0] axle_ff;
   logic [31:0] px_ff, px_in, py_ff, py_in, hd_ff, hd_in, st_ff, st_in;
   logic signed [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [63:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [4:0]  it_ff, it_in;
   logic        flip_ff, flip_in;
   logic [31:0] tang_ff, tang_in;
   logic [1:0]  trig_ff, trig_in;
   logic signed [63:0] s0_ff, s0_in, c0_ff, c0_in, s1_ff, s1_in, c1_ff, c1_in;
   logic signed [95:0] t_ff, t_in, u_ff, u_in;
   logic signed [63:0] w_ff, w_in;
   logic [31:0] nh_ff, nh_in;
   logic        out_v_ff, out_v_in;

   logic alu_start, alu_busy;
   alu_op_type alu_op;
   logic signed [95:0] alu_a, alu_r;
   logic signed [63:0] alu_b;

   mrpi_serial_alu u_alu (
      .clock(clock), .reset(reset), .start(alu_start), .op(alu_op),
      .opa(alu_a), .opb(alu_b), .busy(alu_busy), .result(alu_r)
   );

   logic cfg_wr;
   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (reg_index_type'(csr_paddr[3:2]))
         REG_MODE: csr_prdata = {30'd0, mode_ff};
         REG_STEP: csr_prdata = {16'd0, dt_ff};
         REG_AXLE: csr_prdata = {8'd0, axle_ff};
         default:  csr_prdata = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIFF; dt_ff <= 16'd655; axle_ff <= 24'd65536;
      end else if (cfg_wr) begin
         unique case (reg_index_type'(csr_paddr[3:2]))
            REG_MODE: mode_ff <= csr_pwdata[1:0];
            REG_STEP: dt_ff <= csr_pwdata[15:0];
            REG_AXLE: axle_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   function automatic logic [31:0] sat32(input logic signed [95:0] v);
      if (v > 96'sd2147483647) return 32'h7FFFFFFF;
      if (v < -96'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   logic signed [63:0] dx, dy;
   logic [31:0] angp;
   logic signed [95:0] sx, sy;
   logic [95:0] mag;
   logic [63:0] wb;

   assign req_stall = (state_ff != ST_IDLE) | out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_pos_x = px_ff;
   assign rsp_pos_y = py_ff;
   assign rsp_heading_out = hd_ff;
   assign rsp_steer_out = st_ff;

   always_comb begin
      state_in = state_ff;
      px_in = px_ff; py_in = py_ff; hd_in = hd_ff; st_in = st_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; it_in = it_ff; flip_in = flip_ff;
      tang_in = tang_ff; trig_in = trig_ff;
      s0_in = s0_ff; c0_in = c0_ff; s1_in = s1_ff; c1_in = c1_ff;
      t_in = t_ff; u_in = u_ff; w_in = w_ff; nh_in = nh_ff;
      out_v_in = out_v_ff;
      alu_start = 1'b0; alu_op = OP_MUL; alu_a = '0; alu_b = '0;
      dx = x_ff >>> it_ff;
      dy = y_ff >>> it_ff;
      angp = tang_ff + 32'h40000000;
      sx = '0; sy = '0; mag = '0;
      wb = (axle_ff == 24'd0) ? 64'd1 : {40'd0, axle_ff};
      if (out_v_ff && !rsp_stall) out_v_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (req_valid && !out_v_ff) begin
            a_in = req_action_a; b_in = req_action_b; c_in = req_action_c;
            if (req_opcode) begin
               px_in = req_action_a; py_in = req_action_b; hd_in = req_action_c;
               state_in = ST_DONE;
            end else state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            tang_in = hd_ff; trig_in = 2'd0; state_in = ST_TRIG0;
            t_in = '0;
            if (mode_ff == MODE_DIFF) begin
               if (b_ff != 0) begin
                  w_in = 64'(b_ff); state_in = ST_OMEGA_DT;
               end
            end else if (mode_ff == MODE_ACKER) begin
               if (st_ff != 0) begin
                  alu_start = 1'b1; alu_op = OP_MUL;
                  alu_a = 96'(signed'(st_ff)) <<< 16;
                  alu_b = 64'(INV_PI_Q32);
                  trig_in = 2'd2; state_in = ST_OMEGA_BAM1;
               end
            end
         end
         // w * dt then radians to binary angle
         ST_OMEGA_DT: begin
            alu_start = 1'b1; alu_a = 96'(w_ff); alu_b = {48'd0, dt_ff};
            state_in = ST_OMEGA_BAM1;
         end
         ST_OMEGA_BAM1: if (!alu_busy) begin
            alu_start = 1'b1; alu_a = alu_r; alu_b = 64'(INV_PI_Q32);
            if (trig_ff == 2'd2) begin
               tang_in = 32'(alu_r >>> (FRAC_BITS + 17));
               state_in = ST_TRIG0; alu_start = 1'b0;
            end else state_in = ST_OMEGA_BAM2;
         end
         ST_OMEGA_BAM2: if (!alu_busy) begin
            nh_in = 32'(alu_r >>> (FRAC_BITS + 17));
            state_in = ST_OMEGA_BAM3;
         end
         ST_OMEGA_BAM3: begin
            if (mode_ff == MODE_DIFF) begin
               nh_in = hd_ff + nh_ff; tang_in = hd_ff; trig_in = 2'd0;
               state_in = ST_TRIG0;
            end else state_in = ST_TURN_ADD;
         end
         ST_TURN_ADD: begin
            hd_in = hd_ff + nh_ff;
            if (mode_ff == MODE_ACKER) st_in = b_ff;
            state_in = ST_DONE;
         end
         ST_TRIG0: begin
            flip_in = angp[31];
            z_in = 33'(signed'(angp[31] ? tang_ff + 32'h80000000 : tang_ff));
            x_in = 64'(CORDIC_GAIN_Q30); y_in = '0; it_in = '0;
            state_in = ST_TRIG_RUN;
         end
         ST_TRIG_RUN: begin
            if (!z_ff[32]) begin
               x_in = x_ff - dy; y_in = y_ff + dx;
               z_in = z_ff - 33'(atan_bam(it_ff));
            end else begin
               x_in = x_ff + dy; y_in = y_ff - dx;
               z_in = z_ff + 33'(atan_bam(it_ff));
            end
            it_in = it_ff + 5'd1;
            if (32'(it_ff) == TRIG_STEPS - 1 || it_ff == 5'd31)
               state_in = ST_TRIG_DONE;
         end
         ST_TRIG_DONE: begin
            if (trig_ff == 2'd1) begin
               s1_in = flip_ff ? -y_ff : y_ff; c1_in = flip_ff ? -x_ff : x_ff;
               state_in = ST_ARC1;
            end else if (trig_ff == 2'd2) begin
               s1_in = flip_ff ? -y_ff : y_ff; c1_in = flip_ff ? -x_ff : x_ff;
               state_in = ST_TAN;
            end else begin
               s0_in = flip_ff ? -y_ff : y_ff; c0_in = flip_ff ? -x_ff : x_ff;
               if (mode_ff == MODE_DIFF && b_ff != 0) begin
                  tang_in = nh_ff; trig_in = 2'd1; state_in = ST_TRIG0;
               end else state_in = ST_MV1;
            end
         end
         ST_TAN: begin
            if (c1_ff == 0) begin
               w_in = s1_ff[63] ? -64'sd2147483648 : 64'sd2147483647;
               state_in = ST_ACK1;
            end else if (!alu_busy && !t_ff[0]) begin
               alu_start = 1'b1; alu_op = OP_DIV;
               alu_a = 96'(s1_ff) <<< FRAC_BITS; alu_b = c1_ff;
               t_in[0] = 1'b1;
            end else if (!alu_busy) begin
               t_in[0] = 1'b0;
               w_in = (alu_r > 96'sd2147483647) ? 64'sd2147483647 :
                      (alu_r < -96'sd2147483648) ? -64'sd2147483648 : 64'(alu_r);
               state_in = ST_ACK1;
            end
         end
         ST_ACK1: if (!alu_busy && !t_ff[0]) begin
            alu_start = 1'b1; alu_a = 96'(a_ff); alu_b = w_ff; t_in[0] = 1'b1;
         end else if (!alu_busy && t_ff[0] && !t_ff[1]) begin
            alu_start = 1'b1; alu_op = OP_DIV;
            alu_a = (FRAC_BITS >= 16) ? (alu_r >>> 0) : (alu_r <<< (16 - FRAC_BITS));
            alu_b = wb; t_in[1] = 1'b1;
         end else if (!alu_busy && t_ff[1]) begin
            mag = alu_r[95] ? 96'(-alu_r) : 96'(alu_r);
            if (FRAC_BITS > 16) mag = mag >> (FRAC_BITS - 16);
            if (mag > 96'h7FFFFFFF) mag = 96'h7FFFFFFF;
            w_in = alu_r[95] ? -64'(mag) : 64'(mag);
            t_in[1:0] = 2'b00;
            state_in = ST_ACK2;
         end
         ST_ACK2: begin
            tang_in = hd_ff; trig_in = 2'd3; state_in = ST_TRIG0;
         end
         // rotated move: t = vx*cos - vy*sin, u = vx*sin + vy*cos
         ST_MV1: if (!alu_busy) begin
            alu_start = 1'b1; alu_a = 96'(a_ff); alu_b = c0_ff; state_in = ST_MV2;
         end
         ST_MV2: if (!alu_busy) begin
            t_in = alu_r; alu_start = 1'b1;
            alu_a = (mode_ff == MODE_DIFF || mode_ff == MODE_ACKER) ? 96'sd0 : 96'(b_ff);
            alu_b = s0_ff; state_in = ST_MV3;
         end
         ST_MV3: if (!alu_busy) begin
            t_in = t_ff - alu_r; alu_start = 1'b1;
            alu_a = 96'(a_ff); alu_b = s0_ff; state_in = ST_MV4;
         end
         ST_MV4: if (!alu_busy) begin
            u_in = alu_r; alu_start = 1'b1;
            alu_a = (mode_ff == MODE_DIFF || mode_ff == MODE_ACKER) ? 96'sd0 : 96'(b_ff);
            alu_b = c0_ff; state_in = ST_MV5;
         end
         ST_MV5: if (!alu_busy) begin
            u_in = u_ff + alu_r; alu_start = 1'b1;
            alu_a = t_ff >>> 30; alu_b = {48'd0, dt_ff}; state_in = ST_MV6;
         end
         ST_MV6: if (!alu_busy) begin
            sx = 96'(signed'(px_ff)) + (alu_r >>> 16);
            px_in = sat32(sx); alu_start = 1'b1;
            alu_a = u_ff >>> 30; alu_b = {48'd0, dt_ff}; state_in = ST_MV7;
         end
         ST_MV7: if (!alu_busy) begin
            sy = 96'(signed'(py_ff)) + (alu_r >>> 16);
            py_in = sat32(sy); state_in = ST_MV8;
         end
         ST_MV8: begin
            if (mode_ff == MODE_OMNIW) begin
               w_in = 64'(c_ff); state_in = ST_OMEGA_DT;
            end else if (mode_ff == MODE_ACKER) begin
               if (w_ff == 0 || st_ff == 0) begin
                  st_in = b_ff; state_in = ST_DONE;
               end else state_in = ST_OMEGA_DT;
            end else state_in = ST_DONE;
         end
         // differential arc
         ST_ARC1: if (!alu_busy) begin
            alu_start = 1'b1; alu_a = 96'(a_ff); alu_b = s1_ff - s0_ff;
            state_in = ST_ARC2;
         end
         ST_ARC2: if (!alu_busy && !t_ff[0]) begin
            alu_start = 1'b1; alu_op = OP_DIV; alu_a = alu_r; alu_b = 64'(b_ff);
            t_in[0] = 1'b1;
         end else if (!alu_busy) begin
            t_in = '0;
            px_in = sat32(96'(signed'(px_ff)) + (alu_r >>> ARC_SH));
            alu_start = 1'b1; alu_a = 96'(a_ff); alu_b = c0_ff - c1_ff;
            state_in = ST_ARC3;
         end
         ST_ARC3: if (!alu_busy) begin
            alu_start = 1'b1; alu_op = OP_DIV; alu_a = alu_r; alu_b = 64'(b_ff);
            state_in = ST_ARC4;
         end
         ST_ARC4: if (!alu_busy) begin
            py_in = sat32(96'(signed'(py_ff)) + (alu_r >>> ARC_SH));
            hd_in = nh_ff; state_in = ST_DONE;
         end
         ST_DONE: begin
            out_v_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_TRIG_DONE && trig_ff == 2'd3) begin
         // ackermann move after turn rate: reuse heading trig
         s0_in = flip_ff ? -y_ff : y_ff; c0_in = flip_ff ? -x_ff : x_ff;
         state_in = ST_MV1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; out_v_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0; hd_ff <= '0; st_ff <= '0;
         t_ff <= '0;
      end else begin
         state_ff <= state_in; out_v_ff <= out_v_in;
         px_ff <= px_in; py_ff <= py_in; hd_ff <= hd_in; st_ff <= st_in;
         t_ff <= t_in;
      end
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; it_ff <= it_in;
      flip_ff <= flip_in; tang_ff <= tang_in; trig_ff <= trig_in;
      s0_ff <= s0_in; c0_ff <= c0_in; s1_ff <= s1_in; c1_ff <= c1_in;
      u_ff <= u_in; w_ff <= w_in; nh_ff <= nh_in;
   end
endmodule
`default_nettype wire
